FILE: design/pcs_pkg.sv
// shared types and constants for the prime count sieve
package pcs_pkg;

    localparam int LIMIT_W = 12;
    localparam int COUNT_W = 12;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHK,
        S_MARK,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_cur;
        logic chk;
        logic mark_init;
        logic mark_wr;
        logic adv;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic idx_end;
        logic idx_last;
        logic prime;
        logic sq_in;
        logic mul_in;
    } t_dp_sts;

endpackage

FILE: design/prime_count_sieve.sv
// top level of the prime count sieve
// after reset busy stays high while the composite map is cleared
// one word at a time: busy is high from acceptance until the result strobe cycle
// with L = min(limit, SIEVE_SIZE) the walk checks each index from 2 below L and,
// for each prime p with p*p < L, marks every multiple from p*p below L in the map
// through the single map write port; results cannot stall
module prime_count_sieve
    import pcs_pkg::*;
#(
    parameter int SIEVE_SIZE = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_valid,
    output logic [COUNT_W-1:0] o_prime_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_valid)
    );

    pcs_dp #(
        .SIEVE_SIZE (SIEVE_SIZE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_limit (i_limit),
        .o_sts   (sts),
        .o_count (o_prime_count)
    );

endmodule

FILE: design/pcs_ctrl.sv
// controller state machine of the prime count sieve
module pcs_ctrl
    import pcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy,
    output logic    o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                // one pass over the whole map after reset
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.idx_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.prime && i_sts.sq_in) begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_MARK;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = i_sts.idx_last ? S_DONE : S_CHK;
                end
            end
            S_MARK: begin
                if (i_sts.mul_in) begin
                    o_cmd.mark_wr = 1'b1;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = i_sts.idx_last ? S_DONE : S_CHK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

FILE: design/pcs_dp.sv
// datapath of the prime count sieve: composite map, index, square and multiple counters
module pcs_dp
    import pcs_pkg::*;
#(
    parameter int SIEVE_SIZE = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_dp_sts            o_sts,
    output logic [COUNT_W-1:0] o_count
);

    localparam int IDX_W  = $clog2(SIEVE_SIZE + 1);
    localparam int ADDR_W = $clog2(SIEVE_SIZE);
    localparam int MUL_W  = IDX_W + 1;
    localparam int SQ_W   = IDX_W + 2;
    localparam int CMP_W  = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;

    logic r_map [SIEVE_SIZE];
    logic r_rd_data;

    logic [ADDR_W-1:0]  r_clr;
    logic [IDX_W-1:0]   r_lim;
    logic [IDX_W-1:0]   r_idx;
    logic [SQ_W-1:0]    r_sq;
    logic [MUL_W-1:0]   r_mul;
    logic [COUNT_W-1:0] r_count;

    logic [CMP_W-1:0]  lim_wide;
    logic [IDX_W-1:0]  idx_inc;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;

    // requests beyond the map saturate to its size
    assign lim_wide = (CMP_W'(i_limit) > CMP_W'(SIEVE_SIZE)) ? CMP_W'(SIEVE_SIZE)
                                                             : CMP_W'(i_limit);
    assign idx_inc  = r_idx + 1'b1;

    assign o_sts.clr_last = (r_clr == ADDR_W'(SIEVE_SIZE - 1));
    assign o_sts.idx_end  = (r_idx >= r_lim);
    assign o_sts.idx_last = (idx_inc >= r_lim);
    assign o_sts.prime    = !r_rd_data;
    assign o_sts.sq_in    = (r_sq < SQ_W'(r_lim));
    assign o_sts.mul_in   = (r_mul < MUL_W'(r_lim));
    assign o_count        = r_count;

    // read ahead of the walk; skip the read past the limit
    assign rd_en   = i_cmd.rd_cur || (i_cmd.adv && !o_sts.idx_last);
    assign rd_addr = i_cmd.adv ? idx_inc[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

    // the walk clears each entry it checks, so the map is all zero between words
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = 1'b0;
        priority if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.chk) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[ADDR_W-1:0];
        end else if (i_cmd.mark_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_mul[ADDR_W-1:0];
            wr_data = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_map[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lim   <= IDX_W'(lim_wide);
            r_idx   <= IDX_W'(2);
            r_sq    <= SQ_W'(4);
            r_count <= '0;
        end else begin
            if (i_cmd.chk && !r_rd_data) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.adv) begin
                r_idx <= idx_inc;
                // square of the index, held only while it is below the limit
                if (o_sts.sq_in) begin
                    r_sq <= r_sq + SQ_W'({r_idx, 1'b1});
                end
            end
        end
        if (i_cmd.mark_init) begin
            r_mul <= MUL_W'(r_sq);
        end else if (i_cmd.mark_wr) begin
            r_mul <= r_mul + MUL_W'(r_idx);
        end
    end

endmodule
